// ===== hdl/microwire_eeprom_word_reader_core_defines.svh =====
// ----------------------------------------------------------------------------
// Microwire EEPROM word reader: assertion macros
// Shared concurrent check helpers, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef MICROWIRE_EEPROM_WORD_READER_CORE_DEFINES_SVH
`define MICROWIRE_EEPROM_WORD_READER_CORE_DEFINES_SVH

// Same-cycle implication.
`define MWR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MWR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/mwr_pkg.sv =====
// ----------------------------------------------------------------------------
// Microwire EEPROM word reader package
// Command and register codes, pin encodings, fixed pin tables, result type.
// ----------------------------------------------------------------------------
package mwr_pkg;

  // Item commands
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // Configuration register indices
  localparam logic REG_HOLD = 1'b0;
  localparam logic REG_SWAP = 1'b1;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned HoldW    = 16;
  localparam int unsigned WordW    = 16;
  localparam int unsigned AddrInW  = 8;

  localparam logic [HoldW-1:0] HOLD_RESET = 16'd40;
  localparam logic             SWAP_RESET = 1'b1;

  // Pin vector bits: {D, S, C}
  localparam int unsigned PinW = 3;
  localparam logic [PinW-1:0] PIN_NONE = 3'b000;
  localparam logic [PinW-1:0] PIN_C    = 3'b001;
  localparam logic [PinW-1:0] PIN_S    = 3'b010;
  localparam logic [PinW-1:0] PIN_D    = 3'b100;

  localparam int unsigned HeadSteps = 10;
  localparam int unsigned TailSteps = 4;

  // Preamble clock, start bit, then opcode 10
  function automatic logic [PinW-1:0] head_pins(input logic [3:0] idx);
    logic [PinW-1:0] p;
    case (idx)
      4'd0:    p = PIN_NONE;
      4'd1:    p = PIN_S;
      4'd2:    p = PIN_S | PIN_C;
      4'd3:    p = PIN_S;
      4'd4:    p = PIN_S | PIN_D;
      4'd5:    p = PIN_S | PIN_D | PIN_C;
      4'd6:    p = PIN_S | PIN_D;
      4'd7:    p = PIN_S | PIN_D | PIN_C;
      4'd8:    p = PIN_S;
      4'd9:    p = PIN_S | PIN_C;
      default: p = PIN_NONE;
    endcase
    return p;
  endfunction

  // Deselect tail
  function automatic logic [PinW-1:0] tail_pins(input logic [1:0] idx);
    logic [PinW-1:0] p;
    case (idx)
      2'd0:    p = PIN_NONE;
      2'd1:    p = PIN_S;
      2'd2:    p = PIN_NONE;
      default: p = PIN_C;
    endcase
    return p;
  endfunction

  typedef struct packed {
    logic             chip_select;
    logic             serial_clock;
    logic             serial_out;
    logic             busy_res;
    logic             word_valid;
    logic [WordW-1:0] read_word;
    logic             start_ignored;
  } mwr_result_t;

endpackage

// ===== hdl/mwr_seq.sv =====
// ----------------------------------------------------------------------------
// Microwire EEPROM word reader: step sequencer
// Holds the sequence state and works out one item's result in a single pass.
// ----------------------------------------------------------------------------
`include "microwire_eeprom_word_reader_core_defines.svh"

module mwr_seq #(
  parameter int unsigned ADDRESS_BITS = 8,
  parameter int unsigned DATA_BITS    = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic                                command_i,
  input  logic [mwr_pkg::AddrInW-1:0]         word_address_i,
  input  logic                                serial_in_i,
  input  logic [mwr_pkg::HoldW-1:0]           hold_ticks_i,
  input  logic                                swap_bytes_i,
  output mwr_pkg::mwr_result_t                result_o
);

  localparam int unsigned AddrStart  = mwr_pkg::HeadSteps;
  localparam int unsigned TurnStep   = AddrStart + 2 * ADDRESS_BITS;
  localparam int unsigned DataStart  = TurnStep + 1;
  localparam int unsigned TailStart  = DataStart + 2 * DATA_BITS;
  localparam int unsigned TotalSteps = TailStart + mwr_pkg::TailSteps;
  localparam int unsigned StepW      = $clog2(TotalSteps);
  localparam int unsigned ABitW      = $clog2(ADDRESS_BITS);
  localparam int unsigned AddrExtW   =
    (ADDRESS_BITS > mwr_pkg::AddrInW) ? ADDRESS_BITS : mwr_pkg::AddrInW;

  logic [StepW-1:0]             step_q, step_d;
  logic [mwr_pkg::HoldW-1:0]    hold_q, hold_d;
  logic [ADDRESS_BITS-1:0]      addr_q, addr_d;
  logic [DATA_BITS-1:0]         shift_q, shift_d;
  logic                         running_q, running_d;
  logic [mwr_pkg::PinW-1:0]     pins_q, pins_d;

  logic [mwr_pkg::HoldW-1:0]    hold_eff;
  logic [mwr_pkg::HoldW:0]      cnt_inc;
  logic [StepW:0]               step_inc;
  logic [StepW-1:0]             data_off;
  logic [AddrExtW-1:0]          addr_ext;
  logic                         valid;
  logic                         ignored;
  logic [mwr_pkg::WordW-1:0]    word_raw;
  logic [mwr_pkg::WordW-1:0]    word;

  // Pin levels for step s
  function automatic logic [mwr_pkg::PinW-1:0] pins_for(
    input logic [StepW-1:0]        s,
    input logic [ADDRESS_BITS-1:0] a
  );
    logic [StepW-1:0]         k;
    logic [ABitW-1:0]         abit;
    logic [StepW-1:0]         doff;
    logic [mwr_pkg::PinW-1:0] p;
    k    = s - StepW'(AddrStart);
    abit = ABitW'(ADDRESS_BITS - 1) - ABitW'(k >> 1);
    doff = s - StepW'(DataStart);
    if (s < StepW'(AddrStart)) begin
      p = mwr_pkg::head_pins(4'(s));
    end else if (s < StepW'(TurnStep)) begin
      p = mwr_pkg::PIN_S
        | (a[abit] ? mwr_pkg::PIN_D : mwr_pkg::PIN_NONE)
        | (k[0] ? mwr_pkg::PIN_C : mwr_pkg::PIN_NONE);
    end else if (s == StepW'(TurnStep)) begin
      p = mwr_pkg::PIN_S;
    end else if (s < StepW'(TailStart)) begin
      p = doff[0] ? mwr_pkg::PIN_S : (mwr_pkg::PIN_S | mwr_pkg::PIN_C);
    end else begin
      p = mwr_pkg::tail_pins(2'(s - StepW'(TailStart)));
    end
    return p;
  endfunction

  always_comb begin
    step_d    = step_q;
    hold_d    = hold_q;
    addr_d    = addr_q;
    shift_d   = shift_q;
    running_d = running_q;
    pins_d    = pins_q;
    valid     = 1'b0;
    ignored   = 1'b0;

    hold_eff = (hold_ticks_i == '0) ? mwr_pkg::HoldW'(1) : hold_ticks_i;
    cnt_inc  = {1'b0, hold_q} + (mwr_pkg::HoldW + 1)'(1);
    step_inc = {1'b0, step_q} + (StepW + 1)'(1);
    data_off = step_q - StepW'(DataStart);
    addr_ext = AddrExtW'(word_address_i);

    if (accept_i) begin
      if (command_i == mwr_pkg::CMD_START) begin
        if (running_q) begin
          ignored = 1'b1;
        end else begin
          addr_d    = addr_ext[ADDRESS_BITS-1:0];
          step_d    = '0;
          hold_d    = '0;
          shift_d   = '0;
          running_d = 1'b1;
          pins_d    = pins_for('0, addr_ext[ADDRESS_BITS-1:0]);
        end
      end else if (running_q) begin
        if (cnt_inc >= {1'b0, hold_eff}) begin
          hold_d = '0;
          // sample on the end of each clock-low data step
          if (step_q >= StepW'(DataStart) && step_q < StepW'(TailStart) &&
              data_off[0]) begin
            shift_d = {shift_q[DATA_BITS-2:0], serial_in_i};
          end
          if (step_inc >= (StepW + 1)'(TotalSteps)) begin
            running_d = 1'b0;
            step_d    = '0;
            valid     = 1'b1;
          end else begin
            step_d = step_inc[StepW-1:0];
            pins_d = pins_for(step_inc[StepW-1:0], addr_q);
          end
        end else begin
          hold_d = cnt_inc[mwr_pkg::HoldW-1:0];
        end
      end
    end

    word_raw = mwr_pkg::WordW'(shift_d);
    if (!valid) begin
      word = '0;
    end else if (swap_bytes_i) begin
      word = {word_raw[7:0], word_raw[15:8]};
    end else begin
      word = word_raw;
    end

    result_o.chip_select   = |(pins_d & mwr_pkg::PIN_S);
    result_o.serial_clock  = |(pins_d & mwr_pkg::PIN_C);
    result_o.serial_out    = |(pins_d & mwr_pkg::PIN_D);
    result_o.busy_res      = running_d;
    result_o.word_valid    = valid;
    result_o.read_word     = word;
    result_o.start_ignored = ignored;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= '0;
      hold_q    <= '0;
      addr_q    <= '0;
      shift_q   <= '0;
      running_q <= 1'b0;
      pins_q    <= '0;
    end else begin
      step_q    <= step_d;
      hold_q    <= hold_d;
      addr_q    <= addr_d;
      shift_q   <= shift_d;
      running_q <= running_d;
      pins_q    <= pins_d;
    end
  end

  `MWR_ASSERT_NEXT(a_start_runs, accept_i && command_i == mwr_pkg::CMD_START && !running_q, running_q && step_q == '0 && hold_q == '0, "start did not begin the sequence")
  `MWR_ASSERT_NEXT(a_done_idles, accept_i && result_o.word_valid, !running_q && step_q == '0, "sequence still running after word delivered")
  `MWR_ASSERT_NOW(a_ignore_busy, result_o.start_ignored, running_q && accept_i, "start flagged as ignored while idle")

endmodule

// ===== hdl/microwire_eeprom_word_reader_core.sv =====
// Output: a result is registered and presented in the cycle after its input transfer.
// Throughput: one item per cycle while not stalled; the sequencer state and
//   result register update on each transfer, so free-running timebase ticks flow.
// Reset: asynchronous, active low; sequencer idle with its pins low, hold 40 ticks, swap on.
// A full read takes 63 steps (default sizes) of hold_ticks ticks each; a zero hold counts as one.
// ----------------------------------------------------------------------------
// Microwire EEPROM word reader core
// Bus-master READ of one word from a 93C66-style serial EEPROM. Each item is
// a start or a time tick; each transfer yields one result with the pin
// levels, busy flag and, at completion, the word read.
// ----------------------------------------------------------------------------
`include "microwire_eeprom_word_reader_core_defines.svh"

module microwire_eeprom_word_reader_core #(
  parameter int unsigned ADDRESS_BITS = 8,
  parameter int unsigned DATA_BITS    = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [mwr_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [mwr_pkg::CfgDataW-1:0]     cfg_data_i,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             command_i,
  input  logic [mwr_pkg::AddrInW-1:0]      word_address_i,
  input  logic                             serial_in_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             chip_select_o,
  output logic                             serial_clock_o,
  output logic                             serial_out_o,
  output logic                             busy_res_o,
  output logic                             word_valid_o,
  output logic [mwr_pkg::WordW-1:0]        read_word_o,
  output logic                             start_ignored_o
);

  // Configuration registers
  logic [mwr_pkg::HoldW-1:0] hold_ticks_q;
  logic                      swap_bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ticks_q <= mwr_pkg::HOLD_RESET;
      swap_bytes_q <= mwr_pkg::SWAP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mwr_pkg::REG_HOLD: hold_ticks_q <= cfg_data_i;
        mwr_pkg::REG_SWAP: swap_bytes_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Handshake: the result register takes a new transfer whenever it is
  // empty or being drained this cycle, so input stalls only while a result
  // is held by the receiver.
  logic                 in_xfer;
  logic                 out_valid_q;
  mwr_pkg::mwr_result_t seq_res;
  mwr_pkg::mwr_result_t res_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;

  mwr_seq #(
    .ADDRESS_BITS (ADDRESS_BITS),
    .DATA_BITS    (DATA_BITS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_xfer),
    .command_i      (command_i),
    .word_address_i (word_address_i),
    .serial_in_i    (serial_in_i),
    .hold_ticks_i   (hold_ticks_q),
    .swap_bytes_i   (swap_bytes_q),
    .result_o       (seq_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload: loaded only on an input transfer, so it holds while stalled
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= seq_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign chip_select_o   = res_q.chip_select;
  assign serial_clock_o  = res_q.serial_clock;
  assign serial_out_o    = res_q.serial_out;
  assign busy_res_o      = res_q.busy_res;
  assign word_valid_o    = res_q.word_valid;
  assign read_word_o     = res_q.read_word;
  assign start_ignored_o = res_q.start_ignored;

  `MWR_ASSERT_NEXT(a_xfer_gives_result, in_xfer, out_valid_q, "input transfer produced no result")
  `MWR_ASSERT_NOW(a_empty_never_stalls, !out_valid_q, !in_stall_o, "input stalled with empty result register")
  `MWR_ASSERT_NEXT(a_stalled_result_held, out_valid_q && out_stall_i, out_valid_q, "stalled result dropped")

endmodule

// ===== tb/mwr_word_reader_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Microwire EEPROM word reader: result checker
// Watches the configuration port and both channels, predicts the result of
// every input transfer and compares it field by field with the block's output.
// ----------------------------------------------------------------------------
module mwr_word_reader_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mwr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mwr_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic                         command_i,
  input  logic [mwr_pkg::AddrInW-1:0]  word_address_i,
  input  logic                         serial_in_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic                         chip_select_i,
  input  logic                         serial_clock_i,
  input  logic                         serial_out_i,
  input  logic                         busy_res_i,
  input  logic                         word_valid_i,
  input  logic [mwr_pkg::WordW-1:0]    read_word_i,
  input  logic                         start_ignored_i,
  output int unsigned                  fail_count_o,
  output int                           pending_o
);

  // Step map of one read
  localparam int FirstAddrStep = 10;
  localparam int TurnStep      = FirstAddrStep + 16;
  localparam int FirstDataStep = TurnStep + 1;
  localparam int FirstTailStep = FirstDataStep + 32;
  localparam int StepCount     = FirstTailStep + 4;
  localparam int MaxReports    = 100;

  logic [mwr_pkg::HoldW-1:0]   hold_ticks;
  logic                        swap_on;
  logic [5:0]                  step_idx;
  logic [mwr_pkg::HoldW-1:0]   hold_cnt;
  logic [7:0]                  addr_latch;
  logic [mwr_pkg::WordW-1:0]   shift_reg;
  logic                        running;
  logic [mwr_pkg::PinW-1:0]    pins;

  mwr_pkg::mwr_result_t        pin_word_q[$];
  mwr_pkg::mwr_result_t        want_r;
  mwr_pkg::mwr_result_t        got_r;
  int unsigned                 fails = 0;

  assign fail_count_o = fails;

  // Pin levels of a step; serial bits are data set up, then clock high
  function automatic logic [mwr_pkg::PinW-1:0] step_pins(input logic [5:0] s,
                                                         input logic [7:0] a);
    int                       k;
    logic [2:0]               head_bits;
    logic                     d;
    logic [mwr_pkg::PinW-1:0] p;
    head_bits = 3'b110;  // start bit, then read opcode 10
    k = int'(s);
    d = 1'b0;
    if (k < 4) begin
      case (k)
        0:       p = mwr_pkg::PIN_NONE;
        2:       p = mwr_pkg::PIN_S | mwr_pkg::PIN_C;
        default: p = mwr_pkg::PIN_S;
      endcase
    end else if (k < TurnStep) begin
      if (k < FirstAddrStep) begin
        d = head_bits[2 - ((k - 4) / 2)];
        p = mwr_pkg::PIN_S | (d ? mwr_pkg::PIN_D : mwr_pkg::PIN_NONE)
            | ((((k - 4) % 2) == 1) ? mwr_pkg::PIN_C : mwr_pkg::PIN_NONE);
      end else begin
        d = a[7 - ((k - FirstAddrStep) / 2)];
        p = mwr_pkg::PIN_S | (d ? mwr_pkg::PIN_D : mwr_pkg::PIN_NONE)
            | ((((k - FirstAddrStep) % 2) == 1) ? mwr_pkg::PIN_C : mwr_pkg::PIN_NONE);
      end
    end else if (k == TurnStep) begin
      p = mwr_pkg::PIN_S;
    end else if (k < FirstTailStep) begin
      p = (((k - FirstDataStep) % 2) == 1) ? mwr_pkg::PIN_S
                                           : (mwr_pkg::PIN_S | mwr_pkg::PIN_C);
    end else if (k < StepCount) begin
      case (k - FirstTailStep)
        1:       p = mwr_pkg::PIN_S;
        3:       p = mwr_pkg::PIN_C;
        default: p = mwr_pkg::PIN_NONE;
      endcase
    end else begin
      p = mwr_pkg::PIN_NONE;
    end
    return p;
  endfunction

  // Applies one item to the mirrored reader and gives the pin/word result
  function automatic mwr_pkg::mwr_result_t step_reader(input logic cmd,
                                                       input logic [7:0] addr,
                                                       input logic sin);
    mwr_pkg::mwr_result_t      r;
    logic [mwr_pkg::HoldW:0]   hold_eff;
    logic [mwr_pkg::WordW-1:0] word;
    r = '0;
    if (cmd == mwr_pkg::CMD_START) begin
      if (running) begin
        r.start_ignored = 1'b1;
      end else begin
        addr_latch = addr;
        step_idx   = '0;
        hold_cnt   = '0;
        shift_reg  = '0;
        running    = 1'b1;
        pins       = step_pins(6'd0, addr);
      end
    end else if (running) begin
      hold_eff = (hold_ticks == '0) ? 17'd1 : {1'b0, hold_ticks};
      hold_cnt = hold_cnt + 16'd1;
      if ({1'b0, hold_cnt} >= hold_eff) begin
        hold_cnt = '0;
        // sample on the end of each clock-low data step
        if (int'(step_idx) >= FirstDataStep && int'(step_idx) < FirstTailStep
            && ((int'(step_idx) - FirstDataStep) % 2) == 1)
          shift_reg = {shift_reg[mwr_pkg::WordW-2:0], sin};
        step_idx = step_idx + 6'd1;
        if (int'(step_idx) >= StepCount) begin
          running      = 1'b0;
          step_idx     = '0;
          r.word_valid = 1'b1;
          word         = shift_reg;
          r.read_word  = swap_on ? {word[7:0], word[15:8]} : word;
        end else begin
          pins = step_pins(step_idx, addr_latch);
        end
      end
    end
    r.chip_select  = |(pins & mwr_pkg::PIN_S);
    r.serial_clock = |(pins & mwr_pkg::PIN_C);
    r.serial_out   = |(pins & mwr_pkg::PIN_D);
    r.busy_res     = running;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [mwr_pkg::WordW-1:0] want_v,
                                 input logic [mwr_pkg::WordW-1:0] got_v);
    fails++;
    if (fails <= MaxReports)
      $display("%0t ns: mismatch on %s: expected %h, got %h", $time, what, want_v, got_v);
  endtask

  task automatic compare_field(input string what, input logic [mwr_pkg::WordW-1:0] want_v,
                               input logic [mwr_pkg::WordW-1:0] got_v);
    if (got_v !== want_v) report_mismatch(what, want_v, got_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ticks = mwr_pkg::HOLD_RESET;
      swap_on    = mwr_pkg::SWAP_RESET;
      step_idx   = '0;
      hold_cnt   = '0;
      addr_latch = '0;
      shift_reg  = '0;
      running    = 1'b0;
      pins       = mwr_pkg::PIN_NONE;
      pin_word_q.delete();
      pending_o <= 0;
    end else begin
      // result side first: each result is registered after its transfer, so its expectation is already queued
      if (out_valid_i && !out_stall_i) begin
        got_r = '{chip_select: chip_select_i, serial_clock: serial_clock_i,
                  serial_out: serial_out_i, busy_res: busy_res_i,
                  word_valid: word_valid_i, read_word: read_word_i,
                  start_ignored: start_ignored_i};
        if (pin_word_q.size() == 0) begin
          report_mismatch("result with none expected", '0, read_word_i);
        end else begin
          want_r = pin_word_q.pop_front();
          compare_field("chip_select", mwr_pkg::WordW'(want_r.chip_select),
                        mwr_pkg::WordW'(got_r.chip_select));
          compare_field("serial_clock", mwr_pkg::WordW'(want_r.serial_clock),
                        mwr_pkg::WordW'(got_r.serial_clock));
          compare_field("serial_out", mwr_pkg::WordW'(want_r.serial_out),
                        mwr_pkg::WordW'(got_r.serial_out));
          compare_field("busy_res", mwr_pkg::WordW'(want_r.busy_res),
                        mwr_pkg::WordW'(got_r.busy_res));
          compare_field("word_valid", mwr_pkg::WordW'(want_r.word_valid),
                        mwr_pkg::WordW'(got_r.word_valid));
          compare_field("read_word", want_r.read_word, got_r.read_word);
          compare_field("start_ignored", mwr_pkg::WordW'(want_r.start_ignored),
                        mwr_pkg::WordW'(got_r.start_ignored));
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          mwr_pkg::REG_HOLD: hold_ticks = cfg_data_i;
          mwr_pkg::REG_SWAP: swap_on    = cfg_data_i[0];
          default:  ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        pin_word_q.push_back(step_reader(command_i, word_address_i, serial_in_i));
      pending_o <= pin_word_q.size();
    end
  end

endmodule

// ===== tb/tb_microwire_eeprom_word_reader_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Microwire EEPROM word reader core: testbench top
// Drives start and tick items with random serial data and random idling,
// writes the two registers between phases and gives the verdict from the
// checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_microwire_eeprom_word_reader_core;

  localparam int StepCount     = 63;    // steps of one read at default sizes
  localparam int WatchdogLimit = 2000;  // cycles without any transfer
  localparam int LongHold      = 300;   // receiver hold-off for back-pressure
  localparam int PhaseItems    = 220;

  logic                         clk          = 1'b0;
  logic                         rst_n        = 1'b0;
  logic                         cfg_we       = 1'b0;
  logic [mwr_pkg::CfgIdxW-1:0]  cfg_index    = mwr_pkg::REG_HOLD;
  logic [mwr_pkg::CfgDataW-1:0] cfg_data     = '0;
  logic                         in_valid     = 1'b0;
  logic                         in_stall;
  logic                         command      = mwr_pkg::CMD_TICK;
  logic [mwr_pkg::AddrInW-1:0]  word_address = '0;
  logic                         serial_in    = 1'b0;
  logic                         out_valid;
  logic                         out_stall    = 1'b0;
  logic                         chip_select;
  logic                         serial_clock;
  logic                         serial_out;
  logic                         busy_res;
  logic                         word_valid;
  logic [mwr_pkg::WordW-1:0]    read_word;
  logic                         start_ignored;

  int unsigned         fail_count;
  int                  pending;

  // idling control for sender and receiver
  bit                  no_idle        = 1'b0;
  bit                  send_gaps      = 1'b1;
  bit                  recv_calm      = 1'b0;
  bit                  long_hold_req  = 1'b0;
  bit                  long_hold_done = 1'b0;
  int                  items_sent     = 0;
  int                  cur_hold       = 40;
  int                  stuck_cycles   = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  microwire_eeprom_word_reader_core i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .command_i       (command),
    .word_address_i  (word_address),
    .serial_in_i     (serial_in),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .chip_select_o   (chip_select),
    .serial_clock_o  (serial_clock),
    .serial_out_o    (serial_out),
    .busy_res_o      (busy_res),
    .word_valid_o    (word_valid),
    .read_word_o     (read_word),
    .start_ignored_o (start_ignored)
  );

  mwr_word_reader_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .command_i       (command),
    .word_address_i  (word_address),
    .serial_in_i     (serial_in),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .chip_select_i   (chip_select),
    .serial_clock_i  (serial_clock),
    .serial_out_i    (serial_out),
    .busy_res_i      (busy_res),
    .word_valid_i    (word_valid),
    .read_word_i     (read_word),
    .start_ignored_i (start_ignored),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // Called right after the clock rises; returns once its item has been transferred.
  // This task lowers valid only for a gap and otherwise keeps it high between items.
  task automatic send_item(input logic cmd, input logic [mwr_pkg::AddrInW-1:0] addr,
                           input logic sin);
    int gap;
    if ($urandom_range(0, 149) == 0) send_gaps = !send_gaps;
    if (!no_idle && send_gaps && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    word_address <= addr;
    serial_in    <= sin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Ticks with random pin data; noise puts the odd start in while busy
  task automatic send_ticks(input int n, input int noise_pct);
    for (int i = 0; i < n; i++) begin
      if (noise_pct > 0 && $urandom_range(1, 100) <= noise_pct)
        send_item(mwr_pkg::CMD_START, mwr_pkg::AddrInW'($urandom), 1'($urandom));
      send_item(mwr_pkg::CMD_TICK, mwr_pkg::AddrInW'($urandom), 1'($urandom));
    end
  endtask

  // A whole read: start, exactly enough ticks to finish it, then a few idle ticks
  task automatic run_read(input logic [mwr_pkg::AddrInW-1:0] addr, input int extra);
    send_item(mwr_pkg::CMD_START, addr, 1'($urandom));
    send_ticks(StepCount * ((cur_hold == 0) ? 1 : cur_hold), 3);
    send_ticks(extra, 0);
  endtask

  task automatic run_phase(input int n_items);
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at)
      run_read(mwr_pkg::AddrInW'($urandom), $urandom_range(0, 3));
  endtask

  // Lowers valid, lets every expected result arrive, then a short pause;
  // the checker's pending count is registered, so it is read after an edge
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mwr_pkg::CfgIdxW-1:0] idx,
                           input logic [mwr_pkg::CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [mwr_pkg::CfgDataW-1:0] hold_v,
                            input logic [mwr_pkg::CfgDataW-1:0] swap_v);
    wait_drained();
    write_reg(mwr_pkg::REG_HOLD, hold_v);
    write_reg(mwr_pkg::REG_SWAP, swap_v);
    cur_hold = int'(hold_v);
  endtask

  // Receiver: random stall bursts, calm stretches, and one long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 199) == 0) recv_calm = !recv_calm;
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!no_idle && !recv_calm && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel
  initial begin
    while (stuck_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        stuck_cycles = 0;
      else
        stuck_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset settings (hold 40, swap on)
    send_item(mwr_pkg::CMD_TICK, 8'hFF, 1'b1);    // tick while idle: nothing moves
    send_item(mwr_pkg::CMD_TICK, 8'h00, 1'b0);
    send_item(mwr_pkg::CMD_START, 8'hFF, 1'b0);   // all-ones address
    send_item(mwr_pkg::CMD_START, 8'h00, 1'b1);   // start while busy, flagged
    send_item(mwr_pkg::CMD_TICK, 8'h00, 1'b1);    // first tick counts toward step 0
    send_item(mwr_pkg::CMD_START, 8'hAA, 1'b0);
    send_ticks(45, 1);                   // past the first step boundary at hold 40
    set_config(16'h0001, 16'hFFFE);      // shortest hold mid-read, swap off via bit 0
    send_ticks(StepCount, 0);            // rest of the read, then one idle tick
    send_ticks(3, 0);                    // idle again: CS low, clock high
    run_read(8'h00, 2);                  // all-zeros address
    set_config(16'h0000, 16'h0001);      // zero hold behaves as one
    run_read(8'h5A, 1);

    // Random part; back-pressure stretch in the first phase
    set_config(16'h0001, 16'h0001);
    long_hold_req = 1'b1;
    run_phase(PhaseItems);
    set_config(16'h0002, 16'h0000);
    run_phase(PhaseItems);
    set_config(16'h0000, 16'hFFFE);
    run_phase(PhaseItems);
    set_config(16'h0003, 16'h0001);
    run_phase(PhaseItems);
    set_config(16'h0001, 16'h8000);
    no_idle = 1'b1;
    run_phase(PhaseItems);

    // Longest hold: the counter climbs while the first step stays put
    set_config(16'hFFFF, 16'h7FFF);
    send_item(mwr_pkg::CMD_START, mwr_pkg::AddrInW'($urandom), 1'b0);
    send_ticks(40, 0);

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/mwr_pkg.sv
hdl/mwr_seq.sv
hdl/microwire_eeprom_word_reader_core.sv
tb/mwr_word_reader_checker.sv
tb/tb_microwire_eeprom_word_reader_core.sv
